>>> hdl/ucer_pkg.sv
`timescale 1ns / 1ps
package ucer_pkg;

  localparam int unsigned MaxPacket = 64;
  localparam int unsigned NumEndpoints = 8;
  localparam int unsigned RomSize = 179;

  localparam logic [1:0] HsAck = 2'd0;
  localparam logic [1:0] HsNak = 2'd1;
  localparam logic [1:0] HsStall = 2'd2;

  localparam logic [2:0] CmdSetup = 3'd0;
  localparam logic [2:0] CmdIn = 3'd1;
  localparam logic [2:0] CmdOut = 3'd2;
  localparam logic [2:0] CmdBusReset = 3'd4;

  localparam logic [7:0] ReqGetStatus = 8'd0;
  localparam logic [7:0] ReqClearFeature = 8'd1;
  localparam logic [7:0] ReqSetAddress = 8'd5;
  localparam logic [7:0] ReqGetDescriptor = 8'd6;
  localparam logic [7:0] ReqGetConfig = 8'd8;
  localparam logic [7:0] ReqSetConfig = 8'd9;
  localparam logic [7:0] ReqGetInterface = 8'd10;

  localparam logic [7:0] OfsDev = 8'd0;
  localparam logic [7:0] OfsCfg = 8'd18;
  localparam logic [7:0] OfsLang = 8'd115;
  localparam logic [7:0] OfsManu = 8'd119;
  localparam logic [7:0] OfsProd = 8'd133;
  localparam logic [7:0] OfsJin = 8'd145;
  localparam logic [7:0] OfsJout = 8'd161;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StEmit
  } state_e;

  typedef struct packed {
    logic exec;
    logic load_byte;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic more;
  } stat_t;

  function automatic logic [7:0] rom_byte(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    case (a)
      8'd0: r = 8'h12; 8'd1: r = 8'h01; 8'd2: r = 8'h10; 8'd3: r = 8'h01;
      8'd4: r = 8'h00; 8'd5: r = 8'h00; 8'd6: r = 8'h00; 8'd7: r = 8'(MaxPacket);
      8'd8: r = 8'h86; 8'd9: r = 8'h1a; 8'd10: r = 8'h22; 8'd11: r = 8'h57;
      8'd12: r = 8'h00; 8'd13: r = 8'h01; 8'd14: r = 8'h01; 8'd15: r = 8'h02;
      8'd16: r = 8'h00; 8'd17: r = 8'h01;
      8'd18: r = 8'h09; 8'd19: r = 8'h02; 8'd20: r = 8'h61; 8'd21: r = 8'h00;
      8'd22: r = 8'h02; 8'd23: r = 8'h01; 8'd24: r = 8'h00; 8'd25: r = 8'h80;
      8'd26: r = 8'h32;
      8'd27: r = 8'h09; 8'd28: r = 8'h04; 8'd29: r = 8'h00; 8'd30: r = 8'h00;
      8'd31: r = 8'h00; 8'd32: r = 8'h01; 8'd33: r = 8'h01; 8'd34: r = 8'h00;
      8'd35: r = 8'h00;
      8'd36: r = 8'h09; 8'd37: r = 8'h24; 8'd38: r = 8'h01; 8'd39: r = 8'h00;
      8'd40: r = 8'h01; 8'd41: r = 8'h09; 8'd42: r = 8'h00; 8'd43: r = 8'h01;
      8'd44: r = 8'h01;
      8'd45: r = 8'h09; 8'd46: r = 8'h04; 8'd47: r = 8'h01; 8'd48: r = 8'h00;
      8'd49: r = 8'h02; 8'd50: r = 8'h01; 8'd51: r = 8'h03; 8'd52: r = 8'h00;
      8'd53: r = 8'h00;
      8'd54: r = 8'h07; 8'd55: r = 8'h24; 8'd56: r = 8'h01; 8'd57: r = 8'h00;
      8'd58: r = 8'h01; 8'd59: r = 8'h25; 8'd60: r = 8'h00;
      8'd61: r = 8'h06; 8'd62: r = 8'h24; 8'd63: r = 8'h02; 8'd64: r = 8'h01;
      8'd65: r = 8'h01; 8'd66: r = 8'h05;
      8'd67: r = 8'h06; 8'd68: r = 8'h24; 8'd69: r = 8'h02; 8'd70: r = 8'h02;
      8'd71: r = 8'h02; 8'd72: r = 8'h05;
      8'd73: r = 8'h09; 8'd74: r = 8'h24; 8'd75: r = 8'h03; 8'd76: r = 8'h01;
      8'd77: r = 8'h03; 8'd78: r = 8'h01; 8'd79: r = 8'h02; 8'd80: r = 8'h01;
      8'd81: r = 8'h06;
      8'd82: r = 8'h09; 8'd83: r = 8'h24; 8'd84: r = 8'h03; 8'd85: r = 8'h02;
      8'd86: r = 8'h04; 8'd87: r = 8'h01; 8'd88: r = 8'h01; 8'd89: r = 8'h01;
      8'd90: r = 8'h06;
      8'd91: r = 8'h07; 8'd92: r = 8'h05; 8'd93: r = 8'h02; 8'd94: r = 8'h02;
      8'd95: r = 8'h40; 8'd96: r = 8'h00; 8'd97: r = 8'h00;
      8'd98: r = 8'h05; 8'd99: r = 8'h25; 8'd100: r = 8'h01; 8'd101: r = 8'h01;
      8'd102: r = 8'h01;
      8'd103: r = 8'h07; 8'd104: r = 8'h05; 8'd105: r = 8'h82; 8'd106: r = 8'h02;
      8'd107: r = 8'h40; 8'd108: r = 8'h00; 8'd109: r = 8'h00;
      8'd110: r = 8'h05; 8'd111: r = 8'h25; 8'd112: r = 8'h01; 8'd113: r = 8'h01;
      8'd114: r = 8'h03;
      8'd115: r = 8'h04; 8'd116: r = 8'h03; 8'd117: r = 8'h09; 8'd118: r = 8'h04;
      8'd119: r = 8'h0E; 8'd120: r = 8'h03; 8'd121: r = 8'h77; 8'd123: r = 8'h63;
      8'd125: r = 8'h68; 8'd127: r = 8'h2E; 8'd129: r = 8'h63; 8'd131: r = 8'h6E;
      8'd133: r = 8'h0C; 8'd134: r = 8'h03; 8'd135: r = 8'h43; 8'd137: r = 8'h48;
      8'd139: r = 8'h33; 8'd141: r = 8'h32; 8'd143: r = 8'h56;
      8'd145: r = 8'h10; 8'd146: r = 8'h03; 8'd147: r = 8'h4D; 8'd149: r = 8'h49;
      8'd151: r = 8'h44; 8'd153: r = 8'h49; 8'd155: r = 8'h20; 8'd157: r = 8'h49;
      8'd159: r = 8'h4E;
      8'd161: r = 8'h12; 8'd162: r = 8'h03; 8'd163: r = 8'h4D; 8'd165: r = 8'h49;
      8'd167: r = 8'h44; 8'd169: r = 8'h49; 8'd171: r = 8'h20; 8'd173: r = 8'h4F;
      8'd175: r = 8'h55; 8'd177: r = 8'h54;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/usb_control_endpoint_responder.sv
`timescale 1ns / 1ps
// Standard request responder for a full-speed USB control endpoint.
// Input channel (in_valid_i/in_ready_o) takes one token event per item:
// setup, in, out, frame start, bus reset or suspend, with setup fields.
// Output channel (out_valid_o/out_ready_i) gives one result per byte written
// to the endpoint zero buffer, up to 64, or one result without data.
// The last result of an item is marked by last_o.
// An item is decoded and executed in the cycle after acceptance, in the
// execute state, and its results then leave from the emit state
// one per cycle while the receiver is ready.
// Each item gives N results, N being 1 to 64; the emit state reads the
// descriptor ROM one byte per result for descriptor data.
// The block takes a new item only once all results of the previous one
// have been taken, so a stalled receiver holds the input off as well.
// Reset sets every endpoint to in nak, out ack, toggles zero, and clears
// the device address, configuration and the pending request.
module usb_control_endpoint_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [2:0]  endpoint_i,
  input  logic        toggle_ok_i,
  input  logic [6:0]  rx_length_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_index_i,
  input  logic [15:0] request_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  ep_number_o,
  output logic [1:0]  tx_response_o,
  output logic [1:0]  rx_response_o,
  output logic        tx_toggle_o,
  output logic        rx_toggle_o,
  output logic [6:0]  tx_length_o,
  output logic [7:0]  data_byte_o,
  output logic        data_valid_o,
  output logic        last_o,
  output logic [6:0]  device_address_o,
  output logic        out_accepted_o,
  output logic [6:0]  out_length_o
);

  ucer_pkg::ctrl_t ctrl;
  ucer_pkg::stat_t stat;

  ucer_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i, .out_valid_o,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  ucer_datapath u_dp (
    .clk_i, .rst_ni,
    .in_fire_i(in_valid_i && in_ready_o),
    .command_i, .endpoint_i, .toggle_ok_i, .rx_length_i, .request_type_i,
    .request_code_i, .request_value_i, .request_index_i, .request_length_i,
    .ctrl_i(ctrl), .stat_o(stat),
    .ep_number_o, .tx_response_o, .rx_response_o, .tx_toggle_o, .rx_toggle_o,
    .tx_length_o, .data_byte_o, .data_valid_o, .last_o, .device_address_o,
    .out_accepted_o, .out_length_o
  );

endmodule

>>> hdl/ucer_ctrl.sv
`timescale 1ns / 1ps
module ucer_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  ucer_pkg::stat_t  stat_i,
  output ucer_pkg::ctrl_t  ctrl_o
);

  ucer_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ucer_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ucer_pkg::StIdle: begin
        if (in_valid_i) state_d = ucer_pkg::StExec;
      end
      ucer_pkg::StExec: state_d = ucer_pkg::StEmit;
      ucer_pkg::StEmit: begin
        if (out_ready_i && !stat_i.more) state_d = ucer_pkg::StIdle;
      end
      default: state_d = ucer_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    ctrl_o = '0;
    case (state_q)
      ucer_pkg::StIdle: in_ready_o = 1'b1;
      ucer_pkg::StExec: begin
        ctrl_o.exec = 1'b1;
        ctrl_o.load_byte = 1'b1;
      end
      ucer_pkg::StEmit: begin
        out_valid_o = 1'b1;
        ctrl_o.emit = out_ready_i;
        ctrl_o.load_byte = out_ready_i && stat_i.more;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/ucer_datapath.sv
`timescale 1ns / 1ps
module ucer_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [2:0]       command_i,
  input  logic [2:0]       endpoint_i,
  input  logic             toggle_ok_i,
  input  logic [6:0]       rx_length_i,
  input  logic [7:0]       request_type_i,
  input  logic [7:0]       request_code_i,
  input  logic [15:0]      request_value_i,
  input  logic [15:0]      request_index_i,
  input  logic [15:0]      request_length_i,
  input  ucer_pkg::ctrl_t  ctrl_i,
  output ucer_pkg::stat_t  stat_o,
  output logic [2:0]       ep_number_o,
  output logic [1:0]       tx_response_o,
  output logic [1:0]       rx_response_o,
  output logic             tx_toggle_o,
  output logic             rx_toggle_o,
  output logic [6:0]       tx_length_o,
  output logic [7:0]       data_byte_o,
  output logic             data_valid_o,
  output logic             last_o,
  output logic [6:0]       device_address_o,
  output logic             out_accepted_o,
  output logic [6:0]       out_length_o
);

  localparam int unsigned NE = ucer_pkg::NumEndpoints;

  logic [NE-1:0][1:0] txhs_q, rxhs_q;
  logic [NE-1:0]      txtg_q, rxtg_q;
  logic [6:0]         addr_q;
  logic [7:0]         cfg_q, preq_q, ofs_q;
  logic [15:0]        rem_q;
  logic [6:0]         txcnt_q;

  logic [2:0]  cmd_q, ep_q;
  logic        tok_q;
  logic [6:0]  rxl_q;
  logic [7:0]  rtype_q, rcode_q;
  logic [15:0] rval_q, ridx_q, rlen_q;

  // Emission: source kind, start address, count and index.
  logic [6:0]  n_q, k_q;
  logic [7:0]  src_q;
  logic        rom_q;
  logic [7:0]  fixb_q;
  logic [7:0]  byte_q;
  logic [2:0]  rep_q;
  logic        acc_q;
  logic [6:0]  olen_q;

  function automatic logic [6:0] clip(input logic [15:0] v);
    return (v > 16'(ucer_pkg::MaxPacket)) ? 7'(ucer_pkg::MaxPacket) : v[6:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      cmd_q <= command_i; ep_q <= endpoint_i; tok_q <= toggle_ok_i;
      rxl_q <= rx_length_i; rtype_q <= request_type_i; rcode_q <= request_code_i;
      rval_q <= request_value_i; ridx_q <= request_index_i; rlen_q <= request_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [7:0]  st, sz;
    logic        fnd, err;
    logic [15:0] rem;
    logic [6:0]  n, t;
    if (!rst_ni) begin
      for (int e = 0; e < NE; e++) begin
        txhs_q[e] <= ucer_pkg::HsNak; rxhs_q[e] <= ucer_pkg::HsAck;
      end
      txtg_q <= '0; rxtg_q <= '0; addr_q <= '0; cfg_q <= '0; preq_q <= '0;
      rem_q <= '0; ofs_q <= '0; txcnt_q <= '0;
      n_q <= '0; k_q <= '0; src_q <= '0; rom_q <= 1'b0; fixb_q <= '0;
      rep_q <= '0; acc_q <= 1'b0; olen_q <= '0; byte_q <= '0;
    end else if (ctrl_i.exec) begin
      st = '0; sz = '0; fnd = 1'b0; err = 1'b0; rem = rem_q; n = '0;
      k_q <= '0; rom_q <= 1'b0; fixb_q <= '0; acc_q <= 1'b0; olen_q <= '0;
      rep_q <= ep_q; n_q <= '0;
      case (cmd_q)
        ucer_pkg::CmdSetup: begin
          rep_q <= '0;
          if (rxl_q != 7'd8) begin
            err = 1'b1;
          end else begin
            rem = rlen_q;
            preq_q <= rcode_q;
            if (rtype_q[6:5] != 2'b00) begin
              err = 1'b1;
            end else begin
              case (rcode_q)
                ucer_pkg::ReqGetDescriptor: begin
                  fnd = 1'b1;
                  case (rval_q[15:8])
                    8'd1: st = ucer_pkg::OfsDev;
                    8'd2: st = ucer_pkg::OfsCfg;
                    8'd3: begin
                      case (rval_q[7:0])
                        8'd0: st = ucer_pkg::OfsLang;
                        8'd1: st = ucer_pkg::OfsManu;
                        8'd2: st = ucer_pkg::OfsProd;
                        8'd5: st = ucer_pkg::OfsJin;
                        8'd6: st = ucer_pkg::OfsJout;
                        default: fnd = 1'b0;
                      endcase
                    end
                    default: fnd = 1'b0;
                  endcase
                  if (fnd) begin
                    sz = (st == ucer_pkg::OfsCfg) ? ucer_pkg::rom_byte(st + 8'd2)
                                                  : ucer_pkg::rom_byte(st);
                  end else begin
                    err = 1'b1;
                  end
                  if (rem > {8'd0, sz}) rem = {8'd0, sz};
                  if (fnd) begin
                    n = clip(rem);
                    rom_q <= 1'b1; src_q <= st;
                    ofs_q <= st + {1'b0, n};
                  end
                end
                ucer_pkg::ReqSetAddress: rem = {8'd0, rval_q[7:0]};
                ucer_pkg::ReqGetConfig: begin
                  fixb_q <= cfg_q; n = 7'd1;
                  if (rem > 16'd1) rem = 16'd1;
                end
                ucer_pkg::ReqSetConfig: cfg_q <= rval_q[7:0];
                ucer_pkg::ReqClearFeature: begin
                  if (rtype_q[4:0] != 5'd2) begin
                    err = 1'b1;
                  end else begin
                    case (ridx_q[7:0])
                      8'h82: begin txtg_q[2] <= 1'b0; txhs_q[2] <= ucer_pkg::HsNak; end
                      8'h02: begin rxtg_q[2] <= 1'b0; rxhs_q[2] <= ucer_pkg::HsAck; end
                      8'h81: begin txtg_q[1] <= 1'b0; txhs_q[1] <= ucer_pkg::HsNak; end
                      8'h01: begin rxtg_q[1] <= 1'b0; rxhs_q[1] <= ucer_pkg::HsAck; end
                      default: err = 1'b1;
                    endcase
                  end
                end
                ucer_pkg::ReqGetInterface: begin
                  n = 7'd1;
                  if (rem > 16'd1) rem = 16'd1;
                end
                ucer_pkg::ReqGetStatus: begin
                  n = 7'd2;
                  if (rem > 16'd2) rem = 16'd2;
                end
                default: err = 1'b1;
              endcase
            end
          end
          txtg_q[0] <= 1'b1; rxtg_q[0] <= 1'b1;
          if (err) begin
            txhs_q[0] <= ucer_pkg::HsStall; rxhs_q[0] <= ucer_pkg::HsStall;
            n_q <= '0; rom_q <= 1'b0;
            if (rxl_q == 7'd8) rem_q <= rem;
          end else begin
            if (rtype_q[7]) begin
              t = clip(rem);
              rem_q <= rem - {9'd0, t};
              txcnt_q <= t;
            end else begin
              rem_q <= rem; txcnt_q <= '0;
            end
            txhs_q[0] <= ucer_pkg::HsAck; rxhs_q[0] <= ucer_pkg::HsAck;
            n_q <= n;
          end
        end
        ucer_pkg::CmdIn: begin
          if (ep_q == 3'd0) begin
            if (preq_q == ucer_pkg::ReqGetDescriptor) begin
              n = clip(rem_q);
              rom_q <= 1'b1; src_q <= ofs_q; n_q <= n;
              rem_q <= rem_q - {9'd0, n};
              ofs_q <= ofs_q + {1'b0, n};
              txcnt_q <= n;
              txtg_q[0] <= ~txtg_q[0];
            end else begin
              if (preq_q == ucer_pkg::ReqSetAddress) addr_q <= rem_q[6:0];
              else txcnt_q <= '0;
              rxhs_q[0] <= ucer_pkg::HsAck; txhs_q[0] <= ucer_pkg::HsNak;
              rxtg_q[0] <= 1'b0; txtg_q[0] <= 1'b0;
            end
          end else if (32'(ep_q) < NE) begin
            txtg_q[ep_q] <= ~txtg_q[ep_q];
            txhs_q[ep_q] <= ucer_pkg::HsNak;
          end
        end
        ucer_pkg::CmdOut: begin
          if (ep_q != 3'd0 && 32'(ep_q) < NE && tok_q) begin
            rxtg_q[ep_q] <= ~rxtg_q[ep_q];
            acc_q <= 1'b1; olen_q <= clip({9'd0, rxl_q});
          end
        end
        ucer_pkg::CmdBusReset: begin
          addr_q <= '0;
          for (int e = 0; e < NE; e++) begin
            txhs_q[e] <= ucer_pkg::HsNak; rxhs_q[e] <= ucer_pkg::HsAck;
          end
          txtg_q <= '0; rxtg_q <= '0;
        end
        default: ;
      endcase
    end else if (ctrl_i.emit) begin
      k_q <= k_q + 7'd1;
      if (ctrl_i.load_byte) begin
        byte_q <= rom_q ? ucer_pkg::rom_byte(src_q + {1'b0, k_q} + 8'd1) : 8'h00;
      end
    end
  end

  logic [7:0] emit_byte;
  always_comb begin
    if (n_q == '0) emit_byte = 8'h00;
    else if (rom_q) emit_byte = byte_q;
    else if (k_q == '0) emit_byte = fixb_q;
    else emit_byte = 8'h00;
  end

  logic [7:0] first_rom;
  assign first_rom = ucer_pkg::rom_byte(src_q);

  assign stat_o.more = (n_q != '0) && (k_q + 7'd1 < n_q);

  logic ok;
  assign ok = 32'(rep_q) < NE;
  assign ep_number_o = rep_q;
  assign tx_response_o = ok ? txhs_q[rep_q] : 2'd0;
  assign rx_response_o = ok ? rxhs_q[rep_q] : 2'd0;
  assign tx_toggle_o = ok ? txtg_q[rep_q] : 1'b0;
  assign rx_toggle_o = ok ? rxtg_q[rep_q] : 1'b0;
  assign tx_length_o = txcnt_q;
  assign data_byte_o = (rom_q && n_q != '0 && k_q == '0) ? first_rom : emit_byte;
  assign data_valid_o = n_q != '0;
  assign last_o = !stat_o.more;
  assign device_address_o = addr_q;
  assign out_accepted_o = acc_q;
  assign out_length_o = olen_q;

endmodule

>>> hdl/ucer_checker.sv
`timescale 1ns / 1ps
module ucer_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       last_o,
  input logic       data_valid_o,
  input logic [7:0] data_byte_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input taken while results are pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o ##1 out_valid_o)
    else $error("Result timing after an accepted item is wrong.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !data_valid_o) |-> (last_o && data_byte_o == 8'h00))
    else $error("A result without data must be single and zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("A stalled result was dropped.");

endmodule

bind usb_control_endpoint_responder ucer_checker u_ucer_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .last_o, .data_valid_o, .data_byte_o
);
